### src/hcurve_pkg.sv
// ----------------------------------------------------------------------------
// hcurve_pkg
// Shared types and constants of the heating curve interpolator: item codes,
// status codes, the breakpoint entry layout and the divider request.
// ----------------------------------------------------------------------------
package hcurve_pkg;

    // Temperature width, 1/256 degree fixed point
    localparam int TEMP_W = 16;

    // Divider operand widths: |dy| * dt fits 32 bits, dx fits 16 bits
    localparam int DVD_W = 32;
    localparam int DVS_W = 16;

    // Setpoint reported for an invalid outdoor reading (-100 degrees)
    localparam logic signed [TEMP_W-1:0] INVALID_SETPOINT = -16'sd25600;

    typedef enum logic [1:0] {
        MODE_QUERY  = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_APPEND = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NO_SEG  = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] outdoor;
        logic signed [TEMP_W-1:0] supply;
    } point_t;

    typedef struct packed {
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

endpackage

### src/hcurve_cmd_if.sv
// ----------------------------------------------------------------------------
// hcurve_cmd_if
// Command channel: query, clear or append items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hcurve_cmd_if
    import hcurve_pkg::*;
();
    logic                     valid;
    logic                     ready;
    mode_t                    mode;
    logic signed [TEMP_W-1:0] outdoor_temp;
    logic                     input_ok;
    logic signed [TEMP_W-1:0] point_outdoor;
    logic signed [TEMP_W-1:0] point_supply;

    modport source (
        output valid, mode, outdoor_temp, input_ok, point_outdoor, point_supply,
        input  ready
    );

    modport sink (
        input  valid, mode, outdoor_temp, input_ok, point_outdoor, point_supply,
        output ready
    );
endinterface

### src/hcurve_res_if.sv
// ----------------------------------------------------------------------------
// hcurve_res_if
// Result channel: setpoint and status items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hcurve_res_if
    import hcurve_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] setpoint;
    status_t                  status;

    modport source (
        output valid, setpoint, status,
        input  ready
    );

    modport sink (
        input  valid, setpoint, status,
        output ready
    );
endinterface

### src/hcurve_table.sv
// ----------------------------------------------------------------------------
// hcurve_table
// Breakpoint memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hcurve_table
    import hcurve_pkg::*;
#(
    parameter int MAX_POINTS = 16,
    parameter int IDX_W      = $clog2(MAX_POINTS)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  point_t           wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output point_t           rd_data
);

    point_t mem [MAX_POINTS];

    // Write one breakpoint
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, updated only when rd_en is high
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/hcurve_div.sv
// ----------------------------------------------------------------------------
// hcurve_div
// Unsigned restoring divider, one quotient bit per cycle, DVD_W steps.
// ----------------------------------------------------------------------------
module hcurve_div
    import hcurve_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  div_req_t         req,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVD_W-1:0]  q_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;

    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    rem_sub;
    logic              ge;

    // Shift in the next dividend bit and trial-subtract
    always_comb
    begin
        rem_sh  = {rem_reg, q_reg[DVD_W-1]};
        ge      = (rem_sh >= {1'b0, dvs_reg});
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    // Sequence the steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Hold operands, advance remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### src/heating_curve_interpolator_core.sv
// A query scans, evaluates, then multiplies, starts and awaits the divider for
// an interpolated segment; others go from evaluate to finish, invalid ones
// straight to finish. Clear and append complete on acceptance. One item is
// worked at a time; the rate is set by the one-entry-per-cycle scan over the
// table read port and the 32-step divider. Reset empties the table (count 0).
// ----------------------------------------------------------------------------
// heating_curve_interpolator_core
// Weather-compensation curve: keeps a breakpoint table in memory, scans it for
// the matching segment and interpolates the supply setpoint linearly.
// ----------------------------------------------------------------------------
module heating_curve_interpolator_core
    import hcurve_pkg::*;
#(
    parameter int MAX_POINTS = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    hcurve_cmd_if.sink   cmd,
    hcurve_res_if.source result
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_EVAL  = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_DSTRT = 7'b0010000,
        S_DWAIT = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    // Control state
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              below_reg, below_next;
    logic              above_reg, above_next;
    logic              found_reg, found_next;
    logic              ovalid_reg, ovalid_next;

    // Payload
    logic signed [TEMP_W-1:0] t_reg, t_next;
    logic signed [TEMP_W-1:0] first_y_reg, first_y_next;
    logic signed [TEMP_W-1:0] last_y_reg, last_y_next;
    point_t                   prev_reg, prev_next;
    point_t                   p1_reg, p1_next;
    point_t                   p2_reg, p2_next;
    logic [DVS_W-1:0]         dx_reg, dx_next;
    logic [TEMP_W-1:0]        dt_reg, dt_next;
    logic [TEMP_W-1:0]        dy_mag_reg, dy_mag_next;
    logic                     dy_neg_reg, dy_neg_next;
    logic [DVD_W-1:0]         prod_reg, prod_next;
    logic signed [TEMP_W-1:0] res_sp_reg, res_sp_next;
    status_t                  res_st_reg, res_st_next;
    logic signed [TEMP_W-1:0] osp_reg, osp_next;
    status_t                  ost_reg, ost_next;

    // Table ports
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    point_t           wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    point_t           rd_data;

    // Divider ports
    logic             div_start;
    div_req_t         div_req;
    logic             div_done;
    logic [DVD_W-1:0] div_q;

    logic                  cmd_fire;
    logic [CNT_W-1:0]      cnt_m1;
    logic [IDX_W-1:0]      last_idx;
    logic signed [TEMP_W:0] dx_w, dt_w, dy_w, dy_abs;
    logic signed [TEMP_W:0] q_signed, interp_w;

    hcurve_table #(
        .MAX_POINTS (MAX_POINTS),
        .IDX_W      (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hcurve_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign last_idx  = cnt_m1[IDX_W-1:0];

    // Append writes the next free entry
    assign wr_en   = cmd_fire && (cmd.mode == MODE_APPEND) && (count_reg < CNT_W'(MAX_POINTS));
    assign wr_addr = count_reg[IDX_W-1:0];
    assign wr_data = '{outdoor: cmd.point_outdoor, supply: cmd.point_supply};

    // Segment differences of the matched segment
    assign dx_w   = TEMP_W'(0) + ({p2_reg.outdoor[TEMP_W-1], p2_reg.outdoor}
                                  - {p1_reg.outdoor[TEMP_W-1], p1_reg.outdoor});
    assign dt_w   = {t_reg[TEMP_W-1], t_reg} - {p1_reg.outdoor[TEMP_W-1], p1_reg.outdoor};
    assign dy_w   = {p2_reg.supply[TEMP_W-1], p2_reg.supply}
                    - {p1_reg.supply[TEMP_W-1], p1_reg.supply};
    assign dy_abs = dy_w[TEMP_W] ? -dy_w : dy_w;

    // Apply sign of the quotient and add the left supply value
    assign q_signed = dy_neg_reg ? -$signed({1'b0, div_q[TEMP_W-1:0]})
                                 :  $signed({1'b0, div_q[TEMP_W-1:0]});
    assign interp_w = {p1_reg.supply[TEMP_W-1], p1_reg.supply} + q_signed;

    assign div_start        = (state_reg == S_DSTRT);
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = dx_reg;

    // Next-state logic
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        below_next   = below_reg;
        above_next   = above_reg;
        found_next   = found_reg;
        ovalid_next  = ovalid_reg;
        t_next       = t_reg;
        first_y_next = first_y_reg;
        last_y_next  = last_y_reg;
        prev_next    = prev_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        dx_next      = dx_reg;
        dt_next      = dt_reg;
        dy_mag_next  = dy_mag_reg;
        dy_neg_next  = dy_neg_reg;
        prod_next    = prod_reg;
        res_sp_next  = res_sp_reg;
        res_st_next  = res_st_reg;
        osp_next     = osp_reg;
        ost_next     = ost_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;

        // Drop the output item once taken
        if (result.valid && result.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (cmd.mode)
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        MODE_APPEND:
                        begin
                            if (count_reg < CNT_W'(MAX_POINTS))
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_QUERY:
                        begin
                            t_next = cmd.outdoor_temp;
                            if (count_reg != '0)
                            begin
                                if (!cmd.input_ok)
                                begin
                                    res_sp_next = INVALID_SETPOINT;
                                    res_st_next = ST_INVALID;
                                    state_next  = S_FIN;
                                end
                                else
                                begin
                                    rd_en      = 1'b1;
                                    rd_addr    = '0;
                                    idx_next   = '0;
                                    found_next = 1'b0;
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Entry idx_reg is on the read port; fetch the next one
                rd_en     = 1'b1;
                rd_addr   = idx_reg + 1'b1;
                prev_next = rd_data;
                if (idx_reg == '0)
                begin
                    below_next   = (t_reg < rd_data.outdoor);
                    first_y_next = rd_data.supply;
                end
                else if ((prev_reg.outdoor <= t_reg) && (t_reg <= rd_data.outdoor))
                begin
                    found_next = 1'b1;
                    p1_next    = prev_reg;
                    p2_next    = rd_data;
                end
                if (idx_reg == last_idx)
                begin
                    above_next  = (t_reg > rd_data.outdoor);
                    last_y_next = rd_data.supply;
                    state_next  = S_EVAL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_EVAL:
            begin
                res_st_next = ST_OK;
                dx_next     = dx_w[DVS_W-1:0];
                dt_next     = dt_w[TEMP_W-1:0];
                dy_mag_next = dy_abs[TEMP_W-1:0];
                dy_neg_next = dy_w[TEMP_W];
                state_next  = S_FIN;
                priority if (below_reg)
                begin
                    res_sp_next = first_y_reg;
                end
                else if (above_reg)
                begin
                    res_sp_next = last_y_reg;
                end
                else if (!found_reg)
                begin
                    res_sp_next = '0;
                    res_st_next = ST_NO_SEG;
                end
                else if (dx_w == '0)
                begin
                    res_sp_next = p1_reg.supply;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                prod_next  = DVD_W'(dy_mag_reg * dt_reg);
                state_next = S_DSTRT;
            end

            S_DSTRT:
            begin
                state_next = S_DWAIT;
            end

            S_DWAIT:
            begin
                if (div_done)
                begin
                    res_sp_next = interp_w[TEMP_W-1:0];
                    state_next  = S_FIN;
                end
            end

            S_FIN:
            begin
                // Load the output register once it is free
                if (!ovalid_reg || result.ready)
                begin
                    ovalid_next = 1'b1;
                    osp_next    = res_sp_reg;
                    ost_next    = res_st_reg;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            below_reg  <= 1'b0;
            above_reg  <= 1'b0;
            found_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            below_reg  <= below_next;
            above_reg  <= above_next;
            found_reg  <= found_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        t_reg       <= t_next;
        first_y_reg <= first_y_next;
        last_y_reg  <= last_y_next;
        prev_reg    <= prev_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        dx_reg      <= dx_next;
        dt_reg      <= dt_next;
        dy_mag_reg  <= dy_mag_next;
        dy_neg_reg  <= dy_neg_next;
        prod_reg    <= prod_next;
        res_sp_reg  <= res_sp_next;
        res_st_reg  <= res_st_next;
        osp_reg     <= osp_next;
        ost_reg     <= ost_next;
    end

    assign result.valid    = ovalid_reg;
    assign result.setpoint = osp_reg;
    assign result.status   = ost_reg;

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the heating curve interpolator core. Builds
// breakpoint tables with clear and append items, fires queries at them and
// predicts every setpoint and status. Covers clamping, interpolation,
// zero-width segments, the single point case, invalid readings, a full table
// and random idling and long result back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb
    import hcurve_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAB_DEPTH   = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 80;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]               mode;
        logic signed [TEMP_W-1:0] temp;
        logic                     input_ok;
        logic signed [TEMP_W-1:0] px;
        logic signed [TEMP_W-1:0] py;
    } cmd_item_t;

    typedef struct {
        logic signed [TEMP_W-1:0] setpoint;
        status_t                  status;
    } setpoint_t;

    // Curve model: own copy of the breakpoint table and the queue of setpoints
    // still owed by the block
    class setpoint_scoreboard;
        logic signed [TEMP_W-1:0] outdoor_tab [TAB_DEPTH];
        logic signed [TEMP_W-1:0] supply_tab  [TAB_DEPTH];
        int                       n_points;
        setpoint_t                owed_q [$];
        int unsigned              errors;
        int unsigned              n_ok;
        int unsigned              n_invalid;
        int unsigned              n_no_seg;
        int unsigned              n_appends;
        int unsigned              n_dropped;
        int unsigned              n_clears;

        function new();
            n_points  = 0;
            errors    = 0;
            n_ok      = 0;
            n_invalid = 0;
            n_no_seg  = 0;
            n_appends = 0;
            n_dropped = 0;
            n_clears  = 0;
        endfunction

        // Update the table and work out the setpoint of an accepted item
        function void note_item(cmd_item_t c);
            setpoint_t                r;
            logic signed [TEMP_W-1:0] x1, x2, y1, y2;
            longint                   dx, q;
            bit                       found;
            r.setpoint = '0;
            r.status   = ST_OK;
            found      = 1'b0;
            case (c.mode)
                MODE_CLEAR:
                begin
                    n_points = 0;
                    n_clears++;
                end
                MODE_APPEND:
                begin
                    if (n_points < TAB_DEPTH)
                    begin
                        outdoor_tab[n_points] = c.px;
                        supply_tab[n_points]  = c.py;
                        n_points++;
                        n_appends++;
                    end
                    else
                    begin
                        n_dropped++;
                    end
                end
                MODE_QUERY:
                begin
                    if (n_points == 0)
                        return;
                    if (!c.input_ok)
                    begin
                        r.setpoint = INVALID_SETPOINT;
                        r.status   = ST_INVALID;
                    end
                    else if (c.temp < outdoor_tab[0])
                    begin
                        r.setpoint = supply_tab[0];
                    end
                    else if (c.temp > outdoor_tab[n_points-1])
                    begin
                        r.setpoint = supply_tab[n_points-1];
                    end
                    else
                    begin
                        // scan every segment, the last match wins
                        for (int i = 0; i + 1 < n_points; i++)
                        begin
                            x1 = outdoor_tab[i];
                            x2 = outdoor_tab[i+1];
                            y1 = supply_tab[i];
                            y2 = supply_tab[i+1];
                            if (c.temp >= x1 && c.temp <= x2)
                            begin
                                found = 1'b1;
                                dx    = longint'(x2) - longint'(x1);
                                if (dx == 0)
                                begin
                                    r.setpoint = y1;
                                end
                                else
                                begin
                                    q = ((longint'(y2) - longint'(y1)) *
                                         (longint'(c.temp) - longint'(x1))) / dx;
                                    r.setpoint = TEMP_W'(longint'(y1) + q);
                                end
                            end
                        end
                        if (!found)
                        begin
                            r.setpoint = '0;
                            r.status   = ST_NO_SEG;
                        end
                    end
                    owed_q = {owed_q, r};
                end
                default: ;
            endcase
        endfunction

        // Compare one accepted result with the oldest owed setpoint
        function void check_result(logic signed [TEMP_W-1:0] sp, status_t st);
            setpoint_t e;
            if (owed_q.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, got setpoint %0d status %0d",
                         $time, sp, st);
                errors++;
                return;
            end
            e = owed_q.pop_front();
            if (sp !== e.setpoint)
            begin
                $display("%0t ns: setpoint mismatch, expected %0d, got %0d",
                         $time, e.setpoint, sp);
                errors++;
            end
            if (st !== e.status)
            begin
                $display("%0t ns: status mismatch, expected %0d, got %0d",
                         $time, e.status, st);
                errors++;
            end
            case (e.status)
                ST_OK:      n_ok++;
                ST_INVALID: n_invalid++;
                default:    n_no_seg++;
            endcase
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    int          send_idle_pct;
    int          stall_pct;
    int          hold_req;
    int          hold_seen;
    int          hold_left;
    int unsigned cycle_cnt = 0;
    int unsigned n_sent;

    setpoint_scoreboard sb;

    hcurve_cmd_if cmd_bus ();
    hcurve_res_if res_bus ();

    heating_curve_interpolator_core #(
        .MAX_POINTS (TAB_DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_bus),
        .result (res_bus)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("heating_curve_interpolator_core verification failed");
            $finish;
        end
    end

    function automatic cmd_item_t mk_query(logic signed [TEMP_W-1:0] t, logic ok);
        cmd_item_t c;
        c.mode     = MODE_QUERY;
        c.temp     = t;
        c.input_ok = ok;
        c.px       = TEMP_W'($urandom);
        c.py       = TEMP_W'($urandom);
        return c;
    endfunction

    function automatic cmd_item_t mk_append(logic signed [TEMP_W-1:0] x,
                                            logic signed [TEMP_W-1:0] y);
        cmd_item_t c;
        c.mode     = MODE_APPEND;
        c.temp     = TEMP_W'($urandom);
        c.input_ok = 1'($urandom);
        c.px       = x;
        c.py       = y;
        return c;
    endfunction

    function automatic cmd_item_t mk_clear();
        cmd_item_t c;
        c.mode     = MODE_CLEAR;
        c.temp     = TEMP_W'($urandom);
        c.input_ok = 1'($urandom);
        c.px       = TEMP_W'($urandom);
        c.py       = TEMP_W'($urandom);
        return c;
    endfunction

    // Offer one item, hold it until accepted, leave valid high afterwards
    task automatic send_item(cmd_item_t c);
        if ($urandom_range(99) < send_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        cmd_bus.valid         <= 1'b1;
        cmd_bus.mode          <= mode_t'(c.mode);
        cmd_bus.outdoor_temp  <= c.temp;
        cmd_bus.input_ok      <= c.input_ok;
        cmd_bus.point_outdoor <= c.px;
        cmd_bus.point_supply  <= c.py;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        sb.note_item(c);
        if (c.mode != MODE_UNUSED)
            n_sent++;
    endtask

    // Random tables and queries until the item target is reached
    task automatic run_random(int unsigned n_items);
        int unsigned  stop_at;
        int           k;
        int           n_q;
        int           j;
        longint       lo;
        longint       hi;
        shortint      xs [$];
        shortint      x;
        logic signed [TEMP_W-1:0] t;
        cmd_item_t    c;
        stop_at = n_sent + n_items;
        while (n_sent < stop_at)
        begin
            if ($urandom_range(99) < 80)
            begin
                // well-formed: clear, sorted breakpoints, then queries
                send_item(mk_clear());
                k = ($urandom_range(99) < 70) ? $urandom_range(6, 2)
                                              : $urandom_range(TAB_DEPTH + 1, 1);
                xs.delete();
                for (int i = 0; i < k; i++)
                begin
                    if (i > 0 && $urandom_range(9) == 0)
                        x = xs[i-1];
                    else
                        x = shortint'($urandom);
                    xs = {xs, x};
                end
                xs.sort();
                for (int i = 0; i < k; i++)
                    send_item(mk_append(xs[i], TEMP_W'($urandom)));
                n_q = $urandom_range(8, 2);
                for (int i = 0; i < n_q; i++)
                begin
                    j = $urandom_range(k - 1);
                    case ($urandom_range(4))
                        0: t = TEMP_W'($urandom);
                        1: t = xs[j];
                        2: t = TEMP_W'(longint'(xs[j]) + $urandom_range(6) - 3);
                        default:
                        begin
                            if (j + 1 < k)
                            begin
                                lo = xs[j];
                                hi = xs[j+1];
                                t  = TEMP_W'(lo + ($urandom % (hi - lo + 1)));
                            end
                            else
                            begin
                                t = xs[j];
                            end
                        end
                    endcase
                    send_item(mk_query(t, $urandom_range(15) != 0));
                end
            end
            else
            begin
                // noise: any mode, any content, unsorted tables included
                c.mode     = 2'($urandom);
                c.temp     = TEMP_W'($urandom);
                c.input_ok = 1'($urandom);
                c.px       = TEMP_W'($urandom);
                c.py       = TEMP_W'($urandom);
                send_item(c);
            end
        end
    endtask

    // Result side: random stalls, long hold-off on request, check each item
    initial
    begin
        res_bus.ready = 1'b0;
        hold_seen     = 0;
        hold_left     = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res_bus.valid && res_bus.ready)
                sb.check_result(res_bus.setpoint, res_bus.status);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else
            begin
                res_bus.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Reset, directed part, random phases, drain and verdict
    initial
    begin
        sb                    = new();
        n_sent                = 0;
        hold_req              = 0;
        send_idle_pct         = 0;
        stall_pct             = 0;
        rst_n                 = 1'b0;
        cmd_bus.valid         = 1'b0;
        cmd_bus.mode          = MODE_QUERY;
        cmd_bus.outdoor_temp  = '0;
        cmd_bus.input_ok      = 1'b0;
        cmd_bus.point_outdoor = '0;
        cmd_bus.point_supply  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, then a single point
        send_item(mk_query(16'sd0, 1'b1));
        send_item(mk_append(16'sd0, 16'sd12800));
        send_item(mk_query(16'sd0, 1'b1));
        send_item(mk_query(-16'sd32768, 1'b1));
        send_item(mk_query(16'sd32767, 1'b0));

        // full-range curve with a zero-width step at -5000
        send_item(mk_clear());
        send_item(mk_append(-16'sd32768, 16'sd32767));
        send_item(mk_append(-16'sd5000, 16'sd20000));
        send_item(mk_append(-16'sd5000, 16'sd15000));
        send_item(mk_append(16'sd10000, 16'sd5000));
        send_item(mk_append(16'sd32767, -16'sd32768));
        send_item(mk_query(-16'sd32768, 1'b1));
        send_item(mk_query(-16'sd5000, 1'b1));
        send_item(mk_query(16'sd2500, 1'b1));
        send_item(mk_query(16'sd32767, 1'b1));
        send_item(mk_query(-16'sd1, 1'b1));
        send_item('{MODE_UNUSED, -16'sd1, 1'b1, -16'sd1, -16'sd1});

        // fill past capacity with zero-width steps at the top
        for (int i = 0; i < TAB_DEPTH - 4; i++)
            send_item(mk_append(16'sd32767, TEMP_W'(i * 1000)));
        send_item(mk_query(16'sd32767, 1'b1));

        // no idling, with one long result hold-off
        hold_req <= hold_req + 1;
        run_random(150);
        send_idle_pct = 51;
        run_random(150);
        send_idle_pct = 0;
        stall_pct     = 51;
        run_random(150);
        send_idle_pct = 9;
        stall_pct     = 9;
        run_random(150);
        cmd_bus.valid <= 1'b0;

        // drain, then allow for any stray result
        while (sb.owed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d items: %0d appends (%0d dropped when full), %0d clears.",
                 n_sent, sb.n_appends, sb.n_dropped, sb.n_clears);
        $display("Checked setpoints: %0d normal, %0d invalid reading, %0d no segment.",
                 sb.n_ok, sb.n_invalid, sb.n_no_seg);
        if (sb.errors == 0)
            $display("heating_curve_interpolator_core verification clean");
        else
            $display("heating_curve_interpolator_core verification failed");
        $finish;
    end

endmodule
